@@ rtl/skvt_pkg.sv @@
// package for the sorted key/value table core
// holds field widths, operation and status codes, fsm states and cell structs
// no dependencies
`default_nettype none

package skvt_pkg;

    // field widths
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 3;
    localparam int CAP_W       = 5;
    localparam int COUNT_OUT_W = 5;

    // stream beat widths, padded to whole bytes
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    // operation codes (the spare code behaves as a find)
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_ERASE  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ERASED   = 3'd5;

    // value reported by a find that misses
    localparam logic [VAL_W-1:0] MOST_NEG = 32'h8000_0000;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } t_state;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             ins_en;
        logic             upd_en;
        logic             ers_en;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_ctrl;

    // registered compare result of one cell
    typedef struct packed {
        logic match;
        logic gt;
    } t_cell_flags;

endpackage

`default_nettype wire

@@ rtl/sorted_key_value_table_core.sv @@
// top level of the sorted key/value table: controller, row of slots, output beat
// depends on skvt_pkg and skvt_cell
`default_nettype none

// Sorted key/value table. Commands arrive as beats on the slave stream
// (operation, key, value) and each produces exactly one result beat on the
// master stream (status, found value, entry count).
// Every slot of the row compares its key with the command key in the
// compare state and registers match and greater-than flags; in the update
// state, once the result register is free or being drained, all slots
// update at once, taking the neighbor's pair to open or close a gap.
// The result beat is registered when the update is applied.
// A new command is taken in the update cycle of the previous one while the
// result register is free or being drained, so a waiting result does not
// block the next command from entering. When the receiver stalls with a
// result pending, the following command holds in its update cycle and the
// slave side deasserts tready until the pending beat is taken.
// Reset empties the table (entry count zero), clears the result register
// and sets capacity to 16. Capacity is written through i_cfg_wen and
// i_cfg_wdata while the table is idle; values above DEPTH act as DEPTH.
module sorted_key_value_table_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config
    input  wire logic                               i_cfg_wen,
    input  wire logic [skvt_pkg::CAP_W-1:0]         i_cfg_wdata,
    // command stream
    input  wire logic                               i_s_tvalid,
    output      logic                               o_s_tready,
    // [1:0] operation, [33:2] key, [65:34] value, [71:66] zero
    input  wire logic [skvt_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // result stream
    output      logic                               o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [2:0] status, [34:3] found_value, [39:35] entry_count
    output      logic [skvt_pkg::OUT_DATA_W-1:0]    o_m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > skvt_pkg::CAP_W) ? CW : skvt_pkg::CAP_W) + 1;

    skvt_pkg::t_state r_state;
    skvt_pkg::t_state n_state;

    logic [skvt_pkg::CAP_W-1:0]    r_capacity;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic [skvt_pkg::OP_W-1:0]     r_op;
    logic [skvt_pkg::KEY_W-1:0]    r_key;
    logic [skvt_pkg::VAL_W-1:0]    r_val;

    logic                          r_out_valid;
    logic [skvt_pkg::STATUS_W-1:0] r_out_status;
    logic [skvt_pkg::VAL_W-1:0]    r_out_fval;
    logic [skvt_pkg::COUNT_OUT_W-1:0] r_out_count;

    logic                          w_accept;
    logic                          w_apply_go;
    logic                          w_hit;
    logic                          w_full;
    logic [skvt_pkg::VAL_W-1:0]    w_hit_val;
    logic [skvt_pkg::STATUS_W-1:0] w_status;
    logic [skvt_pkg::VAL_W-1:0]    w_fval;
    skvt_pkg::t_cell_ctrl          w_ctrl;

    logic [DEPTH-1:0]              w_occ;
    logic [DEPTH-1:0]              w_match;
    logic [DEPTH-1:0]              w_gt;
    logic [skvt_pkg::KEY_W-1:0]    w_key  [DEPTH];
    logic [skvt_pkg::VAL_W-1:0]    w_val  [DEPTH];
    logic [skvt_pkg::VAL_W-1:0]    w_hval [DEPTH];
    skvt_pkg::t_cell_flags         w_flags [DEPTH];

    // handshake
    assign w_apply_go = (r_state == skvt_pkg::ST_APPLY) && (!r_out_valid || i_m_tready);
    assign o_s_tready = (r_state == skvt_pkg::ST_IDLE) || w_apply_go;
    assign w_accept   = i_s_tvalid && o_s_tready;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= skvt_pkg::CAP_RESET;
        end else if (i_cfg_wen) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    // command capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_s_tdata[1:0];
            r_key <= i_s_tdata[33:2];
            r_val <= i_s_tdata[65:34];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skvt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            skvt_pkg::ST_IDLE: begin
                if (w_accept) n_state = skvt_pkg::ST_CMP;
            end
            skvt_pkg::ST_CMP: begin
                n_state = skvt_pkg::ST_APPLY;
            end
            skvt_pkg::ST_APPLY: begin
                if (w_apply_go) n_state = w_accept ? skvt_pkg::ST_CMP : skvt_pkg::ST_IDLE;
            end
            default: n_state = skvt_pkg::ST_IDLE;
        endcase
    end

    // hit from the registered match flags, full from count and capacity
    assign w_hit  = |w_match;
    assign w_full = (XW'(r_count) >= XW'(r_capacity)) || (XW'(r_count) >= XW'(DEPTH));

    // combine the per-slot hit values
    always_comb begin
        w_hit_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit_val = w_hit_val | w_hval[i];
        end
    end

    // slot control
    always_comb begin
        w_ctrl        = '0;
        w_ctrl.key    = r_key;
        w_ctrl.value  = r_val;
        unique case (r_state)
            skvt_pkg::ST_CMP: begin
                w_ctrl.cmp_en = 1'b1;
            end
            skvt_pkg::ST_APPLY: begin
                if (w_apply_go && r_op == skvt_pkg::OP_INSERT) begin
                    w_ctrl.upd_en = w_hit;
                    w_ctrl.ins_en = !w_hit && !w_full;
                end
                if (w_apply_go && r_op == skvt_pkg::OP_ERASE) begin
                    w_ctrl.ers_en = w_hit;
                end
            end
            default: begin
                w_ctrl.cmp_en = 1'b0;
            end
        endcase
    end

    // result status, value and next count
    always_comb begin
        w_fval  = '0;
        n_count = r_count;
        priority if (r_op == skvt_pkg::OP_INSERT) begin
            if (w_hit) begin
                w_status = skvt_pkg::STAT_UPDATED;
            end else if (w_full) begin
                w_status = skvt_pkg::STAT_FULL;
            end else begin
                w_status = skvt_pkg::STAT_INSERTED;
                n_count  = r_count + 1'b1;
            end
        end else if (r_op == skvt_pkg::OP_ERASE) begin
            if (w_hit) begin
                w_status = skvt_pkg::STAT_ERASED;
                n_count  = r_count - 1'b1;
            end else begin
                w_status = skvt_pkg::STAT_NOTFOUND;
            end
        end else begin
            w_status = w_hit ? skvt_pkg::STAT_FOUND : skvt_pkg::STAT_NOTFOUND;
            w_fval   = w_hit ? w_hit_val : skvt_pkg::MOST_NEG;
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_apply_go) begin
            r_count <= n_count;
        end
    end

    // result beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result beat payload
    always_ff @(posedge i_clk) begin
        if (w_apply_go) begin
            r_out_status <= w_status;
            r_out_fval   <= w_fval;
            r_out_count  <= skvt_pkg::COUNT_OUT_W'(n_count);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_count, r_out_fval, r_out_status};

    // row of slots
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [skvt_pkg::KEY_W-1:0] w_lkey;
        logic [skvt_pkg::VAL_W-1:0] w_lval;
        logic                       w_lgt;
        logic [skvt_pkg::KEY_W-1:0] w_rkey;
        logic [skvt_pkg::VAL_W-1:0] w_rval;

        assign w_occ[g]   = (r_count > CW'(g));
        assign w_match[g] = w_flags[g].match;
        assign w_gt[g]    = w_flags[g].gt;

        if (g == 0) begin : g_first
            assign w_lkey = '0;
            assign w_lval = '0;
            assign w_lgt  = 1'b0;
        end else begin : g_mid
            assign w_lkey = w_key[g-1];
            assign w_lval = w_val[g-1];
            assign w_lgt  = w_gt[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rkey = '0;
            assign w_rval = '0;
        end else begin : g_inner
            assign w_rkey = w_key[g+1];
            assign w_rval = w_val[g+1];
        end

        skvt_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_occ       (w_occ[g]),
            .i_left_key  (w_lkey),
            .i_left_val  (w_lval),
            .i_left_gt   (w_lgt),
            .i_right_key (w_rkey),
            .i_right_val (w_rval),
            .o_key       (w_key[g]),
            .o_val       (w_val[g]),
            .o_flags     (w_flags[g]),
            .o_hit_val   (w_hval[g])
        );
    end

`ifndef ASSERT_OFF
    // the table never holds more entries than it has slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(DEPTH))
        else $error("entry count above depth");

    // keys are unique, so at most one slot matches when results are formed
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvt_pkg::ST_APPLY) |-> $onehot0(w_match))
        else $error("more than one slot matched");

    // a taken command always goes to the compare cycle next
    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == skvt_pkg::ST_CMP))
        else $error("accepted command did not enter compare");

    // the count moves by at most one per edge
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_count == $past(r_count))
            || (r_count == $past(r_count) + 1'b1)
            || (r_count == $past(r_count) - 1'b1)))
        else $error("entry count jumped");
`endif

endmodule

`default_nettype wire

@@ rtl/skvt_cell.sv @@
// one table slot: a key/value pair with its compare flags
// depends on skvt_pkg for the control and flag structs
`default_nettype none

module skvt_cell (
    input  wire logic                        i_clk,
    input  wire skvt_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic                        i_occ,
    input  wire logic [skvt_pkg::KEY_W-1:0]  i_left_key,
    input  wire logic [skvt_pkg::VAL_W-1:0]  i_left_val,
    input  wire logic                        i_left_gt,
    input  wire logic [skvt_pkg::KEY_W-1:0]  i_right_key,
    input  wire logic [skvt_pkg::VAL_W-1:0]  i_right_val,
    output      logic [skvt_pkg::KEY_W-1:0]  o_key,
    output      logic [skvt_pkg::VAL_W-1:0]  o_val,
    output      skvt_pkg::t_cell_flags       o_flags,
    output      logic [skvt_pkg::VAL_W-1:0]  o_hit_val
);

    logic [skvt_pkg::KEY_W-1:0] r_key;
    logic [skvt_pkg::VAL_W-1:0] r_val;
    logic                       r_match;
    logic                       r_gt;
    logic [skvt_pkg::VAL_W-1:0] r_hit_val;
    logic                       w_eq;
    logic                       w_gt;

    // compare the held key against the broadcast key
    assign w_eq = i_occ && (r_key == i_ctrl.key);
    assign w_gt = i_occ && ($signed(r_key) > $signed(i_ctrl.key));

    // register compare flags and the value on a hit
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match   <= w_eq;
            r_gt      <= w_gt;
            r_hit_val <= w_eq ? r_val : '0;
        end
    end

    // slot update: shift up on insert, shift down on erase, rewrite on update
    always_ff @(posedge i_clk) begin
        if (i_ctrl.ins_en) begin
            if (i_left_gt) begin
                r_key <= i_left_key;
                r_val <= i_left_val;
            end else if (r_gt || !i_occ) begin
                r_key <= i_ctrl.key;
                r_val <= i_ctrl.value;
            end
        end else if (i_ctrl.ers_en) begin
            if (r_match || r_gt) begin
                r_key <= i_right_key;
                r_val <= i_right_val;
            end
        end else if (i_ctrl.upd_en && r_match) begin
            r_val <= i_ctrl.value;
        end
    end

    assign o_key         = r_key;
    assign o_val         = r_val;
    assign o_flags.match = r_match;
    assign o_flags.gt    = r_gt;
    assign o_hit_val     = r_hit_val;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for sorted_key_value_table_core: command and result streams
// a clocked driver and monitor with an in-bench table predictor; depends on skvt_pkg
`timescale 1ns / 1ps

module tb;
    import skvt_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_POOL_N  = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 4;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } table_cmd_t;

    typedef struct {
        logic [STATUS_W-1:0]    status;
        logic [VAL_W-1:0]       found_value;
        logic [COUNT_OUT_W-1:0] entry_count;
    } table_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [CAP_W-1:0]      i_cfg_wdata = '0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    // predicted table contents
    logic signed [KEY_W-1:0] held_keys [TABLE_DEPTH];
    logic signed [VAL_W-1:0] held_values [TABLE_DEPTH];
    int                      held_count = 0;
    int                      cap_setting = 16;

    table_cmd_t              queued_commands [$];
    table_result_t           pending_results [$];
    table_cmd_t              cmd_on_bus;
    table_result_t           expected_beat;
    logic signed [KEY_W-1:0] key_pool [KEY_POOL_N];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_seen = 1'b0;

    sorted_key_value_table_core #(.DEPTH(TABLE_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wen  (i_cfg_wen),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // table predictor: applies one command, returns the result beat it causes
    function automatic table_result_t apply_command(table_cmd_t c);
        table_result_t r;
        int slot;
        int pos;
        int limit;
        r.found_value = '0;
        slot = -1;
        for (int i = 0; i < held_count; i++) begin
            if (held_keys[i] == c.key) slot = i;
        end
        limit = (cap_setting > TABLE_DEPTH) ? TABLE_DEPTH : cap_setting;
        case (c.op)
            OP_INSERT: begin
                if (slot >= 0) begin
                    held_values[slot] = c.value;
                    r.status = STAT_UPDATED;
                end else if (held_count >= limit) begin
                    r.status = STAT_FULL;
                end else begin
                    pos = held_count;
                    while (pos > 0 && $signed(held_keys[pos-1]) > $signed(c.key)) begin
                        held_keys[pos] = held_keys[pos-1];
                        held_values[pos] = held_values[pos-1];
                        pos--;
                    end
                    held_keys[pos] = c.key;
                    held_values[pos] = c.value;
                    held_count++;
                    r.status = STAT_INSERTED;
                end
            end
            OP_ERASE: begin
                if (slot >= 0) begin
                    for (int i = slot; i + 1 < held_count; i++) begin
                        held_keys[i] = held_keys[i+1];
                        held_values[i] = held_values[i+1];
                    end
                    held_count--;
                    r.status = STAT_ERASED;
                end else begin
                    r.status = STAT_NOTFOUND;
                end
            end
            default: begin
                // find, the spare code included
                if (slot >= 0) begin
                    r.found_value = held_values[slot];
                    r.status = STAT_FOUND;
                end else begin
                    r.found_value = MOST_NEG;
                    r.status = STAT_NOTFOUND;
                end
            end
        endcase
        r.entry_count = held_count[COUNT_OUT_W-1:0];
        return r;
    endfunction

    // command driver: predicts each accepted beat, then offers the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                pending_results.push_back(apply_command(cmd_on_bus));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cmd_on_bus <= queued_commands[0];
                    i_s_tdata <= {{(IN_DATA_W-OP_W-KEY_W-VAL_W){1'b0}},
                                  queued_commands[0].value, queued_commands[0].key,
                                  queued_commands[0].op};
                    void'(queued_commands.pop_front());
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_req;
        end
    end

    // result monitor: compares each taken beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
            if (o_m_tvalid && i_m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, o_m_tdata);
                    mismatch_count++;
                end else begin
                    expected_beat = pending_results.pop_front();
                    if (o_m_tdata[2:0] !== expected_beat.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, expected_beat.status, o_m_tdata[2:0]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[34:3] !== expected_beat.found_value) begin
                        $display("%0t: found_value expected %h got %h",
                                 $time, expected_beat.found_value, o_m_tdata[34:3]);
                        mismatch_count++;
                    end
                    if (o_m_tdata[39:35] !== expected_beat.entry_count) begin
                        $display("%0t: entry_count expected %0d got %0d",
                                 $time, expected_beat.entry_count, o_m_tdata[39:35]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic push_cmd(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                            logic [VAL_W-1:0] value);
        table_cmd_t c;
        c.op = op;
        c.key = key;
        c.value = value;
        queued_commands.push_back(c);
    endtask

    // mostly pooled keys so that hits, updates and full tables happen
    task automatic random_phase(int n, int ins_pct, int ers_pct);
        int r;
        logic [OP_W-1:0] op;
        logic [KEY_W-1:0] key;
        @(negedge i_clk);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < ins_pct) op = OP_INSERT;
            else if (r < ins_pct + ers_pct) op = OP_ERASE;
            else if ($urandom_range(9) == 0) op = OP_SPARE;
            else op = OP_FIND;
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL_N-1)];
            else key = $urandom;
            push_cmd(op, key, $urandom);
        end
    endtask

    task automatic wait_drained();
        while (queued_commands.size() != 0 || i_s_tvalid || pending_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_capacity(int cap);
        wait_drained();
        @(posedge i_clk);
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= cap[CAP_W-1:0];
        cap_setting = cap;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int stall_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // stimulus and end of run
    initial begin
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7fff_ffff;
        key_pool[2] = 32'sh0000_0000;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < KEY_POOL_N; i++) begin
            if (i % 2 == 0) key_pool[i] = $urandom;
            else key_pool[i] = $signed(32'($urandom_range(200))) - 100;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, update, every operation, erase gaps
        push_cmd(OP_FIND,   32'h8000_0000, 32'h0000_0000);
        push_cmd(OP_ERASE,  32'h0000_0000, 32'hffff_ffff);
        push_cmd(OP_INSERT, 32'h0000_0000, 32'h7fff_ffff);
        push_cmd(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        push_cmd(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
        push_cmd(OP_INSERT, 32'hffff_ffff, 32'h0000_0001);
        push_cmd(OP_INSERT, 32'h0000_0001, 32'hffff_fffe);
        push_cmd(OP_INSERT, 32'h0000_0000, 32'h5555_5555);
        push_cmd(OP_FIND,   32'h0000_0000, 32'haaaa_aaaa);
        push_cmd(OP_FIND,   32'h8000_0000, 32'h0000_0000);
        push_cmd(OP_FIND,   32'h7fff_ffff, 32'h0000_0000);
        push_cmd(OP_FIND,   32'hffff_ffff, 32'h0000_0000);
        push_cmd(OP_SPARE,  32'h0000_0001, 32'h1234_5678);
        push_cmd(OP_SPARE,  32'h0000_0002, 32'h0000_0000);
        push_cmd(OP_FIND,   32'h0000_0002, 32'h0000_0000);
        push_cmd(OP_ERASE,  32'h8000_0000, 32'h0000_0000);
        push_cmd(OP_ERASE,  32'h7fff_ffff, 32'h0000_0000);
        push_cmd(OP_ERASE,  32'h0000_0000, 32'h0000_0000);
        push_cmd(OP_ERASE,  32'h0000_0007, 32'h0000_0000);
        push_cmd(OP_FIND,   32'h0000_0000, 32'h0000_0000);
        push_cmd(OP_INSERT, 32'hffff_ffff, 32'h8000_0000);

        // capacity zero with entries held: new keys are refused, updates and erases get through
        write_capacity(0);
        random_phase(80, 50, 15);

        // capacity above depth: fill up and hit the full drop, sparse sender
        write_capacity(31);
        set_idling(84, 0);
        random_phase(400, 60, 15);

        // receiver holds off while commands pile up, then sender waits it out
        wait_drained();
        set_idling(0, 0);
        random_phase(40, 60, 10);
        @(negedge i_clk);
        hold_req = ~hold_req;
        wait_drained();

        // capacity lowered below the count, slow receiver
        write_capacity(1);
        set_idling(0, 84);
        random_phase(250, 40, 35);

        write_capacity(4);
        set_idling(37, 37);
        random_phase(300, 45, 25);

        // full capacity, no idling, a sender pause, then a sparse sender
        write_capacity(16);
        set_idling(0, 0);
        random_phase(250, 55, 20);
        wait_drained();
        set_idling(84, 0);
        random_phase(250, 45, 25);

        write_capacity(8);
        set_idling(37, 37);
        random_phase(300, 45, 25);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("sorted_key_value_table_core verification clean");
        end else begin
            $display("sorted_key_value_table_core verification failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("sorted_key_value_table_core verification failed");
        $finish;
    end

endmodule
